// ===== src/scpb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scpb_pkg: shared types and constants of the servo command packet builder
// Holds the configuration record, the packet descriptor that the front end
// hands to the byte serialiser, and the widths of the two dividers.
// ---------------------------------------------------------------------------
package scpb_pkg;

   // Drive mode codes as held in the drive_mode register.
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_JOINT = 2'd1;
   localparam logic [1:0] MODE_WHEEL = 2'd2;

   // Both header bytes of a packet.
   localparam logic [7:0] HEADER_BYTE = 8'hFF;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DRIVE_MODE    = 3'd0,
      REG_SERVO_ID      = 3'd1,
      REG_SPEED_MIN     = 3'd2,
      REG_SPEED_MAX     = 3'd3,
      REG_POS_RANGE_MIN = 3'd4,
      REG_POS_RANGE_MAX = 3'd5,
      REG_SAFETY_MIN    = 3'd6,
      REG_SAFETY_MAX    = 3'd7
   } csr_reg_type;

   // Divider: numerator magnitude, divisor magnitude and quotient bits.
   localparam int NUM_W = 28;
   localparam int DEN_W = 16;
   localparam int QUO_W = 12;
   localparam int CNT_W = $clog2(QUO_W);

   // Mapped value widths.
   localparam int SPD_VAL_W = 11;
   localparam int POS_VAL_W = 12;

   typedef struct packed {
      logic [1:0]         drive_mode;
      logic [7:0]         servo_id;
      logic signed [15:0] speed_min;
      logic [14:0]        speed_max;
      logic signed [15:0] pos_range_min;
      logic signed [15:0] pos_range_max;
      logic signed [15:0] safety_min;
      logic signed [15:0] safety_max;
   } cfg_type;

   typedef struct packed {
      logic                 joint;
      logic [7:0]           servo_id;
      logic [SPD_VAL_W-1:0] speed_val;
      logic [POS_VAL_W-1:0] pos_val;
   } pkt_desc_type;

endpackage

// ===== src/scpb_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scpb_div: iterative restoring divider, one quotient bit per cycle
// Expects the quotient to fit in QUO_W bits; busy stays high from start until
// the last quotient bit is in, and the quotient then holds until the next start.
// ---------------------------------------------------------------------------
module scpb_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [scpb_pkg::NUM_W-1:0] num,
   input  logic [scpb_pkg::DEN_W-1:0] den,
   output logic                       busy,
   output logic [scpb_pkg::QUO_W-1:0] quo
);
   import scpb_pkg::*;

   logic [NUM_W-1:0] rem_ff;
   logic [NUM_W-1:0] rem_in;
   logic [NUM_W-1:0] dsh_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             ge;

   assign ge     = (rem_ff >= dsh_ff);
   assign rem_in = ge ? (rem_ff - dsh_ff) : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(QUO_W - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         dsh_ff <= NUM_W'(den) << (QUO_W - 1);
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dsh_ff <= dsh_ff >> 1;
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

// ===== src/scpb_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scpb_front: command intake, clamping and scaling
// Takes a command, clamps speed and position, forms the scaled numerators and
// divides them on two iterative dividers, then pushes a packet descriptor.
// ---------------------------------------------------------------------------
module scpb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  scpb_pkg::cfg_type      cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     cmd_speed,
   input  logic signed [15:0]     cmd_position,
   output logic                   push,
   output scpb_pkg::pkt_desc_type desc,
   input  logic                   full
);
   import scpb_pkg::*;

   localparam int                   SPD_SCALE    = 1023;
   localparam int                   POS_SCALE    = 4095;
   localparam int                   NUM_S_W      = NUM_W + 1;
   localparam logic [SPD_VAL_W-1:0] SPD_FWD_BASE = 11'd1024;
   localparam logic [SPD_VAL_W-1:0] SPD_FULL     = 11'd1023;
   localparam logic [POS_VAL_W-1:0] POS_FULL     = 12'd4095;

   typedef enum logic [2:0] {
      F_IDLE,
      F_CLAMP,
      F_SCALE,
      F_MAG,
      F_START,
      F_DIV
   } front_state_type;

   front_state_type state_ff;

   logic               joint_ff;
   logic signed [15:0] spd_ff;
   logic signed [15:0] pos_ff;

   // clamp stage
   logic [15:0]          spd_x_in,  spd_x_ff;
   logic [DEN_W-1:0]     spd_den_in, spd_den_ff;
   logic [SPD_VAL_W-1:0] spd_base_in, spd_base_ff;
   logic                 spd_useq_in, spd_useq_ff;
   logic signed [15:0]   pos_lim, pos_c_in, pos_c_ff;

   // scale stage
   logic signed [16:0]   diff_in;
   logic signed [16:0]   den_s_in, den_s_ff;
   logic [NUM_S_W-1:0]   num_s_in, num_s_ff;
   logic [NUM_W-1:0]     spd_num_in, spd_num_ff;

   // magnitude stage
   logic [NUM_S_W-1:0]   num_neg;
   logic [16:0]          den_neg;
   logic [NUM_W-1:0]     num_mag_in, num_mag_ff;
   logic [DEN_W-1:0]     den_mag_in, den_mag_ff;
   logic                 pos_useq_in, pos_useq_ff;
   logic                 pos_sat_ff;

   // speed helpers
   logic signed [15:0]   smax_s;
   logic [15:0]          smax_u;
   logic signed [16:0]   spd_neg;
   logic signed [15:0]   rev_sel;
   logic signed [16:0]   rev_neg;
   logic signed [16:0]   smin_neg;
   logic [15:0]          spd_mag;

   logic                 div_start;
   logic                 spd_busy, pos_busy;
   logic [QUO_W-1:0]     spd_quo, pos_quo;
   logic                 div_done;
   logic                 accept;
   logic                 mode_active;

   assign smax_s   = $signed({1'b0, cfg.speed_max});
   assign smax_u   = {1'b0, cfg.speed_max};
   assign spd_neg  = 17'sd0 - $signed({spd_ff[15], spd_ff});
   assign rev_sel  = (spd_ff < cfg.speed_min) ? cfg.speed_min : spd_ff;
   assign rev_neg  = 17'sd0 - $signed({rev_sel[15], rev_sel});
   assign smin_neg = 17'sd0 - $signed({cfg.speed_min[15], cfg.speed_min});
   assign spd_mag  = spd_ff[15] ? spd_neg[15:0] : spd_ff;

   // Speed clamp and choice of output offset.
   always_comb begin
      spd_x_in    = '0;
      spd_den_in  = smax_u;
      spd_base_in = '0;
      spd_useq_in = 1'b0;
      if (joint_ff) begin
         spd_x_in    = (spd_mag > smax_u) ? smax_u : spd_mag;
         spd_useq_in = (cfg.speed_max != '0);
      end else if (!spd_ff[15]) begin
         spd_x_in    = (spd_ff > smax_s) ? smax_u : spd_ff;
         spd_base_in = SPD_FWD_BASE;
         spd_useq_in = (cfg.speed_max != '0);
      end else if (!cfg.speed_min[15]) begin
         // A reverse limit that is not negative pins the speed to it.
         spd_base_in = (cfg.speed_min == 16'sd0) ? '0 : SPD_FULL;
      end else begin
         spd_x_in    = rev_neg[15:0];
         spd_den_in  = smin_neg[15:0];
         spd_useq_in = 1'b1;
      end
   end

   // Position clamp: range limit on the side of the sign, then safety limits.
   always_comb begin
      pos_lim = pos_ff;
      if (!pos_ff[15]) begin
         if (pos_ff > cfg.pos_range_max) begin
            pos_lim = cfg.pos_range_max;
         end
      end else if (pos_ff < cfg.pos_range_min) begin
         pos_lim = cfg.pos_range_min;
      end
      priority if (pos_lim > cfg.safety_max) begin
         pos_c_in = cfg.safety_max;
      end else if (pos_lim < cfg.safety_min) begin
         pos_c_in = cfg.safety_min;
      end else begin
         pos_c_in = pos_lim;
      end
   end

   assign diff_in  = $signed({pos_c_ff[15], pos_c_ff})
                   - $signed({cfg.pos_range_min[15], cfg.pos_range_min});
   assign den_s_in = $signed({cfg.pos_range_max[15], cfg.pos_range_max})
                   - $signed({cfg.pos_range_min[15], cfg.pos_range_min});
   assign num_s_in = {{(NUM_S_W - 17){diff_in[16]}}, diff_in} * NUM_S_W'(POS_SCALE);
   assign spd_num_in = NUM_W'(spd_x_ff) * NUM_W'(SPD_SCALE);

   assign num_neg    = NUM_S_W'(0) - num_s_ff;
   assign den_neg    = 17'd0 - den_s_ff;
   assign num_mag_in = num_s_ff[NUM_S_W-1] ? num_neg[NUM_W-1:0] : num_s_ff[NUM_W-1:0];
   assign den_mag_in = den_s_ff[16] ? den_neg[DEN_W-1:0] : den_s_ff[DEN_W-1:0];
   // A zero or negative quotient saturates to zero, so only like signs divide.
   assign pos_useq_in = (den_s_ff != 17'sd0) && (num_s_ff != '0)
                      && (num_s_ff[NUM_S_W-1] == den_s_ff[16]);

   assign div_start   = (state_ff == F_START);
   assign div_done    = (state_ff == F_DIV) && !spd_busy && !pos_busy;
   assign push        = div_done && !full;
   assign req_ready   = (state_ff == F_IDLE) || push;
   assign accept      = req_valid && req_ready;
   assign mode_active = (cfg.drive_mode == MODE_JOINT) || (cfg.drive_mode == MODE_WHEEL);

   always_comb begin
      desc.joint     = joint_ff;
      desc.servo_id  = cfg.servo_id;
      desc.speed_val = spd_base_ff + (spd_useq_ff ? spd_quo[SPD_VAL_W-1:0] : '0);
      if (!pos_useq_ff) begin
         desc.pos_val = '0;
      end else if (pos_sat_ff) begin
         desc.pos_val = POS_FULL;
      end else begin
         desc.pos_val = pos_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (accept && mode_active) begin
                  state_ff <= F_CLAMP;
               end
            end
            F_CLAMP: state_ff <= F_SCALE;
            F_SCALE: state_ff <= F_MAG;
            F_MAG:   state_ff <= F_START;
            F_START: state_ff <= F_DIV;
            F_DIV: begin
               if (push) begin
                  state_ff <= (accept && mode_active) ? F_CLAMP : F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         joint_ff <= (cfg.drive_mode == MODE_JOINT);
         spd_ff   <= cmd_speed;
         pos_ff   <= cmd_position;
      end
      if (state_ff == F_CLAMP) begin
         spd_x_ff    <= spd_x_in;
         spd_den_ff  <= spd_den_in;
         spd_base_ff <= spd_base_in;
         spd_useq_ff <= spd_useq_in;
         pos_c_ff    <= pos_c_in;
      end
      if (state_ff == F_SCALE) begin
         num_s_ff   <= num_s_in;
         den_s_ff   <= den_s_in;
         spd_num_ff <= spd_num_in;
      end
      if (state_ff == F_MAG) begin
         num_mag_ff  <= num_mag_in;
         den_mag_ff  <= den_mag_in;
         pos_useq_ff <= pos_useq_in;
      end
      if (state_ff == F_START) begin
         pos_sat_ff <= (num_mag_ff >= {den_mag_ff, {QUO_W{1'b0}}});
      end
   end

   scpb_div u_spd_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (spd_num_ff),
      .den   (spd_den_ff),
      .busy  (spd_busy),
      .quo   (spd_quo)
   );

   scpb_div u_pos_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_mag_ff),
      .den   (den_mag_ff),
      .busy  (pos_busy),
      .quo   (pos_quo)
   );

endmodule

// ===== src/scpb_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scpb_queue: two-entry descriptor queue between front end and serialiser
// Push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module scpb_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  scpb_pkg::pkt_desc_type push_desc,
   output logic                   full,
   input  logic                   pop,
   output scpb_pkg::pkt_desc_type pop_desc,
   output logic                   empty
);
   import scpb_pkg::*;

   pkt_desc_type entry_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_desc = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== src/scpb_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scpb_back: packet byte serialiser
// Walks a descriptor byte by byte into a registered output, summing the body
// for the checksum, and loads the next descriptor when idle or on the final byte.
// ---------------------------------------------------------------------------
module scpb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   output logic                   pop,
   input  scpb_pkg::pkt_desc_type desc_in,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_byte,
   output logic                   out_last
);
   import scpb_pkg::*;

   localparam logic [7:0] INSTR_WRITE = 8'h03;
   localparam logic [7:0] LEN_WHEEL   = 8'h05;
   localparam logic [7:0] LEN_JOINT   = 8'h07;
   localparam logic [7:0] ADDR_SPEED  = 8'h20;
   localparam logic [7:0] ADDR_GOAL   = 8'h1E;

   // Byte positions within a packet.
   localparam logic [3:0] BYTE_HDR0  = 4'd0;
   localparam logic [3:0] BYTE_HDR1  = 4'd1;
   localparam logic [3:0] BYTE_ID    = 4'd2;
   localparam logic [3:0] BYTE_LEN   = 4'd3;
   localparam logic [3:0] BYTE_INSTR = 4'd4;
   localparam logic [3:0] BYTE_ADDR  = 4'd5;
   localparam logic [3:0] BYTE_D0    = 4'd6;
   localparam logic [3:0] BYTE_D1    = 4'd7;
   localparam logic [3:0] BYTE_D2    = 4'd8;
   localparam logic [3:0] BYTE_D3    = 4'd9;
   localparam logic [3:0] BYTE_CS_J  = 4'd10;
   localparam logic [3:0] BYTE_CS_W  = 4'd8;

   pkt_desc_type cur_ff;
   logic         active_ff;
   logic [3:0]   idx_ff;
   logic [7:0]   sum_ff;
   logic [7:0]   byte_ff;
   logic         last_ff;
   logic         valid_ff;

   logic [7:0]   byte_now;
   logic         is_last;
   logic         emit;

   assign emit    = active_ff && (!valid_ff || out_ready);
   assign is_last = (idx_ff == (cur_ff.joint ? BYTE_CS_J : BYTE_CS_W));
   assign pop     = !empty && (!active_ff || (emit && is_last));

   always_comb begin
      unique case (idx_ff)
         BYTE_HDR0, BYTE_HDR1: byte_now = HEADER_BYTE;
         BYTE_ID:    byte_now = cur_ff.servo_id;
         BYTE_LEN:   byte_now = cur_ff.joint ? LEN_JOINT : LEN_WHEEL;
         BYTE_INSTR: byte_now = INSTR_WRITE;
         BYTE_ADDR:  byte_now = cur_ff.joint ? ADDR_GOAL : ADDR_SPEED;
         BYTE_D0:    byte_now = cur_ff.joint ? cur_ff.pos_val[7:0] : cur_ff.speed_val[7:0];
         BYTE_D1:    byte_now = cur_ff.joint ? {4'd0, cur_ff.pos_val[11:8]}
                                             : {5'd0, cur_ff.speed_val[10:8]};
         BYTE_D2:    byte_now = cur_ff.joint ? cur_ff.speed_val[7:0] : ~sum_ff;
         BYTE_D3:    byte_now = {6'd0, cur_ff.speed_val[9:8]};
         BYTE_CS_J:  byte_now = ~sum_ff;
         default:    byte_now = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         idx_ff    <= '0;
         sum_ff    <= '0;
      end else begin
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
         // A newly loaded descriptor restarts the walk, also on the final
         // byte of the previous packet.
         if (pop) begin
            active_ff <= 1'b1;
            idx_ff    <= '0;
            sum_ff    <= '0;
         end else if (emit) begin
            idx_ff <= idx_ff + 4'd1;
            if (idx_ff >= BYTE_ID) begin
               sum_ff <= sum_ff + byte_now;
            end
            if (is_last) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= byte_now;
         last_ff <= is_last;
      end
      if (pop) begin
         cur_ff <= desc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

// ===== src/servo_command_packet_builder_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// servo_command_packet_builder_core: serial-servo write packet builder
// Turns speed/position commands into complete write packets, one byte per
// response, with header, ID, length, instruction, address, data and checksum.
// ---------------------------------------------------------------------------
// Use: each request on req_ carries one command (speed and position). In
// joint mode an eleven-byte packet to the goal-position address follows; in
// wheel mode a nine-byte packet to the moving-speed address. With no mode
// set, requests are taken and dropped without any response. rsp_tlast marks
// the checksum byte that ends each packet.
// Timing: a command passes the clamp, scale, magnitude and start steps,
// then the two 12-step iterative dividers; the descriptor then passes the
// queue entry and the serialiser's descriptor register to its output register.
// The serialiser then sends one byte per cycle while the receiver is ready;
// a packet on the response side runs in parallel with the next command's work.
// A two-entry descriptor queue lets the front end run ahead while the
// receiver stalls; once it is full, a finished descriptor holds req_tready low until room frees.
// Reset (synchronous) empties the queue and restores the register defaults:
// no mode, ID 1, speed limits -1023 and 1023, both ranges 0 to 4095.
// Configuration is to be written through csr_ only while no command is in flight; the block does not enforce this.
// ---------------------------------------------------------------------------
module servo_command_packet_builder_core (
   input  logic                           clock,
   input  logic                           reset,
   // request: [15:0] cmd_speed, [31:16] cmd_position
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,
   // response: [7:0] tx_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,
   output logic                           rsp_tlast,
   input  logic                           csr_wr_en,
   input  logic [scpb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [scpb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import scpb_pkg::*;

   // Register defaults after reset.
   localparam cfg_type CFG_RESET = '{
      drive_mode:    MODE_NONE,
      servo_id:      8'd1,
      speed_min:     -16'sd1023,
      speed_max:     15'd1023,
      pos_range_min: 16'sd0,
      pos_range_max: 16'sd4095,
      safety_min:    16'sd0,
      safety_max:    16'sd4095
   };

   cfg_type      cfg_ff;
   logic         q_push;
   logic         q_full;
   logic         q_pop;
   logic         q_empty;
   pkt_desc_type push_desc;
   pkt_desc_type pop_desc;

   // Configuration registers: plain writes, no read-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_DRIVE_MODE:    cfg_ff.drive_mode    <= csr_wdata[1:0];
            REG_SERVO_ID:      cfg_ff.servo_id      <= csr_wdata[7:0];
            REG_SPEED_MIN:     cfg_ff.speed_min     <= $signed(csr_wdata);
            REG_SPEED_MAX:     cfg_ff.speed_max     <= csr_wdata[14:0];
            REG_POS_RANGE_MIN: cfg_ff.pos_range_min <= $signed(csr_wdata);
            REG_POS_RANGE_MAX: cfg_ff.pos_range_max <= $signed(csr_wdata);
            REG_SAFETY_MIN:    cfg_ff.safety_min    <= $signed(csr_wdata);
            REG_SAFETY_MAX:    cfg_ff.safety_max    <= $signed(csr_wdata);
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Front end: clamping, scaling and division.
   scpb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .cmd_speed    ($signed(req_tdata[15:0])),
      .cmd_position ($signed(req_tdata[31:16])),
      .push         (q_push),
      .desc         (push_desc),
      .full         (q_full)
   );

   // Descriptor queue decoupling the two halves.
   scpb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_desc  (pop_desc),
      .empty     (q_empty)
   );

   // Back end: byte serialiser with checksum and registered output.
   scpb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .pop       (q_pop),
      .desc_in   (pop_desc),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   // The front end never writes into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("descriptor pushed into a full queue");

   // The serialiser never takes a descriptor from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("descriptor popped from an empty queue");

   // After a checksum byte is taken, anything shown next starts a new header.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid || rsp_tdata == HEADER_BYTE))
      else $error("packet did not restart with a header byte");

   // A command that builds a packet occupies the front end on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready
       && (cfg_ff.drive_mode == MODE_JOINT || cfg_ff.drive_mode == MODE_WHEEL))
      |=> !req_tready)
      else $error("front end took a request while still working");

endmodule
